FILE: src/kds_pkg.sv
// Shared constants, codes and types for the keyed deque store.
package kds_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int VALUE_W      = 64;
  localparam int COUNT_OUT_W  = 5;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FIRST  = 3'd2;
  localparam logic [2:0] OP_REMOVE_KEY = 3'd3;
  localparam logic [2:0] OP_FIND_KEY   = 3'd4;
  localparam logic [2:0] OP_READ_FIRST = 3'd5;
  localparam logic [2:0] OP_ROTATE     = 3'd6;
  localparam logic [2:0] OP_CLEAR      = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                 exec;
    logic [2:0]           op;
    logic [KEY_W-1:0]     req_key;
    logic [KEY_W-1:0]     ld_key;
    logic [VALUE_W-1:0]   ld_value;
  } cell_ctl_t;

endpackage

FILE: src/kds_cell.sv
// One storage cell of the deque chain: holds an entry, compares its key, shifts.
module kds_cell #(
  parameter int IDX      = 0,
  parameter int CAPACITY = kds_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  kds_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]               count,
  input  logic [kds_pkg::KEY_W-1:0]   left_key,
  input  logic [kds_pkg::VALUE_W-1:0] left_value,
  input  logic [kds_pkg::KEY_W-1:0]   right_key,
  input  logic [kds_pkg::VALUE_W-1:0] right_value,
  input  logic                        seen_in,
  output logic [kds_pkg::KEY_W-1:0]   key_r,
  output logic [kds_pkg::VALUE_W-1:0] value_r,
  output logic                        hit,
  output logic                        seen_out
);

  logic                        occupied;
  logic                        not_full;
  logic                        take_load;
  logic                        take_left;
  logic                        take_right;
  logic [kds_pkg::KEY_W-1:0]   key_nxt;
  logic [kds_pkg::VALUE_W-1:0] value_nxt;

  assign occupied = count > CW'(IDX);
  assign not_full = count != CW'(CAPACITY);
  assign hit      = occupied && (key_r == ctl.req_key);
  assign seen_out = seen_in | hit;

  always_comb begin
    take_load  = 1'b0;
    take_left  = 1'b0;
    take_right = 1'b0;
    unique case (ctl.op)
      kds_pkg::OP_PUSH_FRONT: begin
        if (not_full) begin
          if (IDX == 0) take_load = 1'b1;
          else take_left = count >= CW'(IDX);
        end
      end
      kds_pkg::OP_PUSH_BACK: begin
        take_load = not_full && (count == CW'(IDX));
      end
      kds_pkg::OP_POP_FIRST: begin
        take_right = count > CW'(IDX + 1);
      end
      kds_pkg::OP_REMOVE_KEY: begin
        // Every cell at or behind the first match closes the gap.
        take_right = seen_out && (count > CW'(IDX + 1));
      end
      kds_pkg::OP_ROTATE: begin
        take_right = count > CW'(IDX + 1);
        take_load  = count == CW'(IDX + 1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (take_load) begin
      key_nxt   = ctl.ld_key;
      value_nxt = ctl.ld_value;
    end else if (take_left) begin
      key_nxt   = left_key;
      value_nxt = left_value;
    end else if (take_right) begin
      key_nxt   = right_key;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

FILE: src/keyed_deque_store_core.sv
// Keyed deque store: a chain of entry cells with an idle/execute request controller.
// A request word accepted while idle is registered and executed in the execute state,
// which waits while a stalled result still holds the output register; the result
// word is then registered on the output. The input stalls during execution, so a
// new request word is taken only after the previous one has been executed.
// Reset (synchronous, rst_n low) empties the store and drops any pending result.
module keyed_deque_store_core #(
  parameter int CAPACITY = kds_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_req_type,
  input  logic [kds_pkg::KEY_W-1:0]         in_key,
  input  logic [kds_pkg::VALUE_W-1:0]       in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [kds_pkg::KEY_W-1:0]         out_key,
  output logic [kds_pkg::VALUE_W-1:0]       out_value,
  output logic [kds_pkg::COUNT_OUT_W-1:0]   out_item_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // The controller has two states: waiting for a request word, and executing it.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                        state_r, state_nxt;
  logic [2:0]                  op_r;
  logic [kds_pkg::KEY_W-1:0]   req_key_r;
  logic [kds_pkg::VALUE_W-1:0] req_value_r;
  logic [CW-1:0]               count_r, count_nxt;

  logic                        out_valid_r;
  logic [1:0]                  out_status_r, status_nxt;
  logic [kds_pkg::KEY_W-1:0]   out_key_r, res_key;
  logic [kds_pkg::VALUE_W-1:0] out_value_r, res_value;
  logic [kds_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic                        accept;
  logic                        fire;
  logic                        found;
  logic                        is_empty;
  logic                        is_full;
  kds_pkg::cell_ctl_t          ctl;

  logic [kds_pkg::KEY_W-1:0]   cell_key   [CAPACITY];
  logic [kds_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]         cell_hit;
  logic [CAPACITY:0]           seen;

  // A request word is taken only while idle; a finished result may still be
  // waiting in the output register at that time.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The execute cycle waits only if the output register cannot be freed.
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(CAPACITY));

  // Everything the cells need is broadcast in one bundle. Rotate reloads the
  // last occupied cell with the head entry; inserts load the request entry.
  always_comb begin
    ctl.exec    = fire;
    ctl.op      = op_r;
    ctl.req_key = req_key_r;
    if (op_r == kds_pkg::OP_ROTATE) begin
      ctl.ld_key   = cell_key[0];
      ctl.ld_value = cell_value[0];
    end else begin
      ctl.ld_key   = req_key_r;
      ctl.ld_value = req_value_r;
    end
  end

  // The chain of cells. Each cell sees its neighbors' entries for shifting and
  // passes along whether a matching key has already been seen nearer the front.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [kds_pkg::KEY_W-1:0]   lk, rk;
    logic [kds_pkg::VALUE_W-1:0] lv, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
    end else begin : g_mid_l
      assign lk = cell_key[i-1];
      assign lv = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_mid_r
      assign rk = cell_key[i+1];
      assign rv = cell_value[i+1];
    end
    kds_cell #(
      .IDX      (i),
      .CAPACITY (CAPACITY),
      .CW       (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .left_key    (lk),
      .left_value  (lv),
      .right_key   (rk),
      .right_value (rv),
      .seen_in     (seen[i]),
      .key_r       (cell_key[i]),
      .value_r     (cell_value[i]),
      .hit         (cell_hit[i]),
      .seen_out    (seen[i+1])
    );
  end

  assign found = seen[CAPACITY];

  // Result entry: the head for pop and read, the first match for remove and
  // find. The select is one-hot or empty, so an OR across cells picks it and a
  // failed request naturally gives zero.
  always_comb begin
    logic rd_head;
    logic srch;
    logic sel;
    rd_head   = (op_r == kds_pkg::OP_POP_FIRST) || (op_r == kds_pkg::OP_READ_FIRST);
    srch      = (op_r == kds_pkg::OP_REMOVE_KEY) || (op_r == kds_pkg::OP_FIND_KEY);
    res_key   = '0;
    res_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel = (rd_head && (i == 0) && !is_empty) || (srch && cell_hit[i] && !seen[i]);
      if (sel) begin
        res_key   = res_key | cell_key[i];
        res_value = res_value | cell_value[i];
      end
    end
  end

  // Status and the new entry count.
  always_comb begin
    status_nxt = kds_pkg::ST_OK;
    count_nxt  = count_r;
    unique case (op_r) inside
      kds_pkg::OP_PUSH_FRONT, kds_pkg::OP_PUSH_BACK: begin
        if (is_full) status_nxt = kds_pkg::ST_FULL;
        else count_nxt = count_r + CW'(1);
      end
      kds_pkg::OP_POP_FIRST: begin
        if (is_empty) status_nxt = kds_pkg::ST_EMPTY;
        else count_nxt = count_r - CW'(1);
      end
      kds_pkg::OP_READ_FIRST, kds_pkg::OP_ROTATE: begin
        if (is_empty) status_nxt = kds_pkg::ST_EMPTY;
      end
      kds_pkg::OP_REMOVE_KEY: begin
        if (is_empty) status_nxt = kds_pkg::ST_EMPTY;
        else if (!found) status_nxt = kds_pkg::ST_MISSING;
        else count_nxt = count_r - CW'(1);
      end
      kds_pkg::OP_FIND_KEY: begin
        if (!found) status_nxt = kds_pkg::ST_MISSING;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_req_type;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
    if (fire) begin
      out_status_r <= status_nxt;
      out_key_r    <= res_key;
      out_value_r  <= res_value;
      out_count_r  <= kds_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_key        = out_key_r;
  assign out_value      = out_value_r;
  assign out_item_count = out_count_r;

endmodule

FILE: src/kds_checker.sv
// Port-level checker for the keyed deque store, bound to the top level.
module kds_checker #(
  parameter int CAPACITY = kds_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_status,
  input logic [kds_pkg::KEY_W-1:0]       out_key,
  input logic [kds_pkg::VALUE_W-1:0]     out_value,
  input logic [kds_pkg::COUNT_OUT_W-1:0] out_item_count
);

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in work");

  // A failed request returns a zero entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != kds_pkg::ST_OK) |-> (out_key == '0) && (out_value == '0))
    else $error("failed request returned a nonzero entry");

  // A refused insert leaves the store full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == kds_pkg::ST_FULL) |->
      (out_item_count == kds_pkg::COUNT_OUT_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  // An empty status means the store holds nothing.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == kds_pkg::ST_EMPTY) |-> (out_item_count == '0))
    else $error("empty status with a nonzero count");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_key)
      && $stable(out_value) && $stable(out_item_count))
    else $error("stalled result word changed");

endmodule

bind keyed_deque_store_core kds_checker #(.CAPACITY(CAPACITY)) u_kds_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyed deque store core.
module tb_top;
  import kds_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // One request word as offered on the input channel.
  typedef struct packed {
    logic [2:0]             op;
    logic [KEY_W-1:0]       key;
    logic [VALUE_W-1:0]     value;
  } request_t;

  // One reply word as it should appear on the result channel.
  typedef struct packed {
    logic [1:0]             status;
    logic [KEY_W-1:0]       key;
    logic [VALUE_W-1:0]     value;
    logic [COUNT_OUT_W-1:0] count;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             in_req_type = OP_PUSH_FRONT;
  logic [KEY_W-1:0]       in_key = '0;
  logic [VALUE_W-1:0]     in_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_status;
  logic [KEY_W-1:0]       out_key;
  logic [VALUE_W-1:0]     out_value;
  logic [COUNT_OUT_W-1:0] out_item_count;

  // Requests waiting to be offered, and replies that the block still owes us.
  request_t request_queue[$];
  reply_t   reply_queue[$];

  // Our own copy of the store contents, updated as each word is accepted.
  logic [KEY_W-1:0]   shadow_keys[DEPTH];
  logic [VALUE_W-1:0] shadow_values[DEPTH];
  int                 shadow_count = 0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  holding = 1'b0;
  bit  in_taken = 1'b0;
  int  mismatch_count = 0;
  int  cycle_count = 0;

  keyed_deque_store_core #(.CAPACITY(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_key        (out_key),
    .out_value      (out_value),
    .out_item_count (out_item_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Deletes one position of the shadow store and closes the gap behind it.
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) begin
      shadow_keys[i]   = shadow_keys[i + 1];
      shadow_values[i] = shadow_values[i + 1];
    end
    shadow_count--;
  endfunction

  // Executes one request on the shadow store and returns the reply it earns.
  // Failed requests and inserts, rotates and clears all return a zero key and
  // value; only reads, finds and removals hand back an entry.
  function automatic reply_t execute_request(request_t rq);
    reply_t             rp;
    int                 i;
    int                 pos;
    logic [KEY_W-1:0]   head_key;
    logic [VALUE_W-1:0] head_value;
    rp = '0;
    rp.status = ST_OK;
    case (rq.op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          rp.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) begin
            shadow_keys[i]   = shadow_keys[i - 1];
            shadow_values[i] = shadow_values[i - 1];
          end
          shadow_keys[0]   = rq.key;
          shadow_values[0] = rq.value;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          rp.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count]   = rq.key;
          shadow_values[shadow_count] = rq.value;
          shadow_count++;
        end
      end
      OP_POP_FIRST, OP_READ_FIRST: begin
        if (shadow_count == 0) begin
          rp.status = ST_EMPTY;
        end else begin
          rp.key   = shadow_keys[0];
          rp.value = shadow_values[0];
          if (rq.op == OP_POP_FIRST) drop_entry(0);
        end
      end
      OP_REMOVE_KEY, OP_FIND_KEY: begin
        // An empty store reads as empty for a removal but as a miss for a find.
        if (shadow_count == 0) begin
          rp.status = (rq.op == OP_REMOVE_KEY) ? ST_EMPTY : ST_MISSING;
        end else begin
          // The match nearest the front wins when keys repeat.
          pos = shadow_count;
          for (i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_keys[i] == rq.key) pos = i;
          end
          if (pos == shadow_count) begin
            rp.status = ST_MISSING;
          end else begin
            rp.key   = shadow_keys[pos];
            rp.value = shadow_values[pos];
            if (rq.op == OP_REMOVE_KEY) drop_entry(pos);
          end
        end
      end
      OP_ROTATE: begin
        if (shadow_count == 0) begin
          rp.status = ST_EMPTY;
        end else begin
          head_key   = shadow_keys[0];
          head_value = shadow_values[0];
          for (i = 0; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
          end
          shadow_keys[shadow_count - 1]   = head_key;
          shadow_values[shadow_count - 1] = head_value;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    rp.count = COUNT_OUT_W'(shadow_count);
    return rp;
  endfunction

  function automatic void add_request(logic [2:0] op, logic [KEY_W-1:0] key,
                                      logic [VALUE_W-1:0] value);
    request_t rq;
    rq.op    = op;
    rq.key   = key;
    rq.value = value;
    request_queue.push_back(rq);
  endfunction

  // Keys mostly come from a tiny pool so that finds and removals hit often
  // and duplicates are common; the rest are extremes or fully random.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 55) return KEY_W'($urandom_range(5));
    if (r < 65) return '0;
    if (r < 75) return '1;
    return $urandom;
  endfunction

  // Filling blocks favor inserts so the store reaches full; draining blocks
  // favor removals so it runs dry again.
  function automatic logic [2:0] pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 25) return OP_PUSH_FRONT;
      if (r < 50) return OP_PUSH_BACK;
      if (r < 58) return OP_POP_FIRST;
      if (r < 68) return OP_REMOVE_KEY;
      if (r < 80) return OP_FIND_KEY;
      if (r < 88) return OP_READ_FIRST;
      if (r < 98) return OP_ROTATE;
      return OP_CLEAR;
    end
    if (r < 10) return OP_PUSH_FRONT;
    if (r < 20) return OP_PUSH_BACK;
    if (r < 45) return OP_POP_FIRST;
    if (r < 65) return OP_REMOVE_KEY;
    if (r < 77) return OP_FIND_KEY;
    if (r < 85) return OP_READ_FIRST;
    if (r < 95) return OP_ROTATE;
    return OP_CLEAR;
  endfunction

  // Queues a batch of random requests under the given idling mix and waits
  // until the driver has handed every one of them to the block.
  task automatic run_phase(int count, int send_pct, int recv_pct);
    int i;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < count; i++) begin
      add_request(pick_op(((i / 30) % 2) == 0), pick_key(), {$urandom, $urandom});
    end
    while (request_queue.size() > 0) @(posedge clk);
  endtask

  // Stimulus sequencing. The directed words come first and walk the store
  // through empty, full and back, touching each corner case; random phases
  // with different idling mixes follow.
  initial begin
    int i;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Pop, read, rotate, remove and find against an empty store.
    add_request(OP_POP_FIRST,  '0, '0);
    add_request(OP_READ_FIRST, '0, '0);
    add_request(OP_ROTATE,     '0, '0);
    add_request(OP_REMOVE_KEY, KEY_W'(5), '0);
    add_request(OP_FIND_KEY,   KEY_W'(5), '0);
    // Fill to capacity from both ends, with the key and value extremes and a
    // repeated key spread through the chain.
    for (i = 0; i < DEPTH; i++) begin
      add_request((i % 2 == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                  (i == 0) ? KEY_W'(0) : (i == 1) ? '1 :
                  (i % 4 == 2) ? KEY_W'(5) : KEY_W'($urandom),
                  (i == 0) ? VALUE_W'(0) : (i == 1) ? '1 : {$urandom, $urandom});
    end
    // Both inserts must be refused while full.
    add_request(OP_PUSH_FRONT, 32'hdead_beef, '1);
    add_request(OP_PUSH_BACK,  32'hdead_beef, '1);
    // Duplicate handling, a miss on a full store, then the remaining ops.
    add_request(OP_FIND_KEY,   KEY_W'(5), '0);
    add_request(OP_REMOVE_KEY, 32'h8765_4321, '0);
    add_request(OP_REMOVE_KEY, KEY_W'(5), '0);
    add_request(OP_ROTATE,     '0, '0);
    add_request(OP_READ_FIRST, '0, '0);
    add_request(OP_POP_FIRST,  '0, '0);
    add_request(OP_CLEAR,      '0, '0);
    // A rotate with a single entry leaves the store as it was.
    add_request(OP_PUSH_BACK,  32'h1234_5678, 64'h0123_4567_89ab_cdef);
    add_request(OP_ROTATE,     '0, '0);
    add_request(OP_READ_FIRST, '0, '0);
    while (request_queue.size() > 0) @(posedge clk);

    run_phase(350, 0, 0);
    run_phase(350, 84, 0);
    run_phase(350, 0, 84);
    run_phase(350, 31, 31);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering words, so the block fills and stalls its input.
    @(posedge clk);
    holding = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end
    join_none
    run_phase(40, 0, 0);

    // Drain: wait for every owed reply, then watch a little longer for
    // stray words.
    while (request_queue.size() > 0 || in_valid || reply_queue.size() > 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && reply_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: a new word goes out at the falling edge once the previous one
  // was taken (or the channel was idle); a stalled word stays put.
  always @(negedge clk) begin : driver
    request_t rq;
    if (rst_n && (!in_valid || in_taken)) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rq = request_queue.pop_front();
        in_req_type <= rq.op;
        in_key      <= rq.key;
        in_value    <= rq.value;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, including the long hold-off stretch.
  always @(negedge clk) begin
    out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: checks each reply word against the oldest prediction, then
  // predicts the reply for any request word accepted at this same edge.
  always @(posedge clk) begin : monitor
    request_t seen;
    reply_t   want;
    reply_t   got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.key    = out_key;
        got.value  = out_value;
        got.count  = out_item_count;
        if (reply_queue.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] unexpected reply: status=%0d key=%h value=%h count=%0d",
                     $realtime, got.status, got.key, got.value, got.count);
          end
          mismatch_count++;
        end else begin
          want = reply_queue.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.value !== want.value || got.count !== want.count) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("[%0t] reply mismatch: expected status=%0d key=%h value=%h count=%0d",
                       $realtime, want.status, want.key, want.value, want.count);
              $display("[%0t]                 actual   status=%0d key=%h value=%h count=%0d",
                       $realtime, got.status, got.key, got.value, got.count);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.op    = in_req_type;
        seen.key   = in_key;
        seen.value = in_value;
        reply_queue.push_back(execute_request(seen));
      end
    end
  end

  // Watchdog against a hung block or a lost reply.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
src/kds_pkg.sv
src/kds_cell.sv
src/keyed_deque_store_core.sv
src/kds_checker.sv
test/tb_top.sv
